// ===== rtl/core/lrc_pkg.sv =====
// lrc_pkg: shared constants and types for the LRU key/value cache.
// No dependencies; imported by every module of the cache.
`timescale 1ns / 1ps

package lrc_pkg;

  localparam int DEPTH_DEF = 16;           // default number of slots
  localparam int CAP_W     = 5;            // width of the capacity register
  localparam int CAP_RESET = 16;           // capacity after reset, before saturation
  localparam int DATA_W    = 32;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [DATA_W-1:0] READ_MISS = {DATA_W{1'b1}};

  // what the current beat does to the store
  typedef struct packed {
    logic put;     // command is a put
    logic hit;     // key present
    logic fill;    // put miss into a free slot
    logic evict;   // put miss replacing the least recent entry
  } lrc_action_t;

endpackage

// ===== rtl/core/lru_key_value_cache.sv =====
// A taken beat goes into the input stage register, then its result into the result register.
// One beat per cycle while the result side does not stall; the whole lookup and LRU update
// of one beat fits between the input stage register and the result register.
// Reset (rst, synchronous): clears all valid bits, the fill count and both
// pipeline valids; capacity returns to min(16, DEPTH). No clearing pass.
`timescale 1ns / 1ps

module lru_key_value_cache #(
  parameter int DEPTH = lrc_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lrc_pkg::CAP_W-1:0]          capacity,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               command,
  input  logic signed [lrc_pkg::DATA_W-1:0]  key,
  input  logic signed [lrc_pkg::DATA_W-1:0]  write_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               hit,
  output logic signed [lrc_pkg::DATA_W-1:0]  read_value,
  output logic                               evicted,
  output logic signed [lrc_pkg::DATA_W-1:0]  evicted_key
);
  import lrc_pkg::*;

  localparam int RANK_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [CAP_W-1:0] CAP_INIT =
    (CAP_RESET > DEPTH) ? CAP_W'(DEPTH) : CAP_W'(CAP_RESET);

  // capacity register
  logic [CAP_W-1:0] cap;
  logic [CAP_W-1:0] cap_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    priority if (32'(capacity) > DEPTH) begin
      cap_next = CAP_W'(DEPTH);
    end else if (capacity == '0) begin
      cap_next = CAP_W'(1);
    end else begin
      cap_next = capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_INIT;
    end else if (cfg_valid && cfg_ready) begin
      cap <= cap_next;
    end
  end

  // input stage
  logic              s1_valid;
  logic              s1_cmd;
  logic [DATA_W-1:0] s1_key;
  logic [DATA_W-1:0] s1_wv;
  logic              s1_go;
  logic              in_take;

  assign s1_go    = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd <= command;
      s1_key <= key;
      s1_wv  <= write_value;
    end
  end

  // lookup and store
  lrc_action_t                   act;
  logic [DEPTH-1:0]              sel;
  logic [RANK_W-1:0]             limit;
  logic [DATA_W-1:0]             read_data;
  logic [DATA_W-1:0]             victim_key;
  logic [DEPTH-1:0]              valid_vec;
  logic [DEPTH-1:0][DATA_W-1:0]  keys;
  logic [DEPTH-1:0][DATA_W-1:0]  values;
  logic [DEPTH-1:0][RANK_W-1:0]  ranks;
  logic [CNT_W-1:0]              fill_count;

  lrc_lookup #(
    .DEPTH  (DEPTH),
    .RANK_W (RANK_W),
    .CNT_W  (CNT_W)
  ) u_lookup (
    .command    (s1_cmd),
    .key        (s1_key),
    .valid_vec  (valid_vec),
    .keys       (keys),
    .values     (values),
    .ranks      (ranks),
    .fill_count (fill_count),
    .capacity   (cap),
    .act        (act),
    .sel        (sel),
    .limit      (limit),
    .read_data  (read_data),
    .victim_key (victim_key)
  );

  lrc_store #(
    .DEPTH  (DEPTH),
    .RANK_W (RANK_W),
    .CNT_W  (CNT_W)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .en          (s1_go),
    .act         (act),
    .sel         (sel),
    .limit       (limit),
    .key         (s1_key),
    .write_value (s1_wv),
    .valid_vec   (valid_vec),
    .keys        (keys),
    .values      (values),
    .ranks       (ranks),
    .fill_count  (fill_count)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      hit         <= act.hit;
      read_value  <= (act.hit && !act.put) ? read_data : READ_MISS;
      evicted     <= act.evict;
      evicted_key <= act.evict ? victim_key : '0;
    end
  end

endmodule

// ===== rtl/core/lrc_lookup.sv =====
// lrc_lookup: parallel key compare, free-slot and victim selection.
// Purely combinational; depends on lrc_pkg.
`timescale 1ns / 1ps

module lrc_lookup #(
  parameter int DEPTH  = lrc_pkg::DEPTH_DEF,
  parameter int RANK_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic                                   command,
  input  logic [lrc_pkg::DATA_W-1:0]             key,
  input  logic [DEPTH-1:0]                       valid_vec,
  input  logic [DEPTH-1:0][lrc_pkg::DATA_W-1:0]  keys,
  input  logic [DEPTH-1:0][lrc_pkg::DATA_W-1:0]  values,
  input  logic [DEPTH-1:0][RANK_W-1:0]           ranks,
  input  logic [CNT_W-1:0]                       fill_count,
  input  logic [lrc_pkg::CAP_W-1:0]              capacity,
  output lrc_pkg::lrc_action_t                   act,
  output logic [DEPTH-1:0]                       sel,
  output logic [RANK_W-1:0]                      limit,
  output logic [lrc_pkg::DATA_W-1:0]             read_data,
  output logic [lrc_pkg::DATA_W-1:0]             victim_key
);
  import lrc_pkg::*;

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [DEPTH-1:0]  match;
  logic [DEPTH-1:0]  victim;
  logic [DEPTH-1:0]  free_sel;
  logic [RANK_W-1:0] hit_rank;
  logic [CNT_W-1:0]  fill_m1;
  logic [RANK_W-1:0] oldest;
  logic              room;
  logic              is_put;

  assign fill_m1 = fill_count - CNT_W'(1);
  assign oldest  = fill_m1[RANK_W-1:0];
  assign room    = CMP_W'(fill_count) < CMP_W'(capacity);
  assign is_put  = (command == CMD_PUT);

  // lowest clear bit of the valid vector, one-hot
  assign free_sel = ~valid_vec & (valid_vec + DEPTH'(1));

  // keys are unique among valid slots and valid ranks are a permutation of
  // 0..fill-1, so both selects are at most one-hot and an AND-OR read works
  always_comb begin
    hit_rank   = '0;
    read_data  = '0;
    victim_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match[i]  = valid_vec[i] && (keys[i] == key);
      victim[i] = valid_vec[i] && (ranks[i] == oldest);
      hit_rank   = hit_rank   | (ranks[i]  & {RANK_W{match[i]}});
      read_data  = read_data  | (values[i] & {DATA_W{match[i]}});
      victim_key = victim_key | (keys[i]   & {DATA_W{victim[i]}});
    end
  end

  always_comb begin
    act.put   = is_put;
    act.hit   = |match;
    act.fill  = !act.hit && is_put && room;
    act.evict = !act.hit && is_put && !room;
  end

  always_comb begin
    priority if (act.hit) begin
      sel   = match;
      limit = hit_rank;
    end else if (act.fill) begin
      sel   = free_sel;
      limit = oldest;
    end else if (act.evict) begin
      sel   = victim;
      limit = oldest;
    end else begin
      sel   = '0;
      limit = oldest;
    end
  end

endmodule

// ===== rtl/core/lrc_store.sv =====
// lrc_store: key, value, valid and recency-rank storage with LRU update.
// Depends on lrc_pkg; takes its update decision from lrc_lookup.
`timescale 1ns / 1ps

module lrc_store #(
  parameter int DEPTH  = lrc_pkg::DEPTH_DEF,
  parameter int RANK_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  lrc_pkg::lrc_action_t                   act,
  input  logic [DEPTH-1:0]                       sel,
  input  logic [RANK_W-1:0]                      limit,
  input  logic [lrc_pkg::DATA_W-1:0]             key,
  input  logic [lrc_pkg::DATA_W-1:0]             write_value,
  output logic [DEPTH-1:0]                       valid_vec,
  output logic [DEPTH-1:0][lrc_pkg::DATA_W-1:0]  keys,
  output logic [DEPTH-1:0][lrc_pkg::DATA_W-1:0]  values,
  output logic [DEPTH-1:0][RANK_W-1:0]           ranks,
  output logic [CNT_W-1:0]                       fill_count
);
  import lrc_pkg::*;

  logic             upd;
  logic [DEPTH-1:0] age;

  assign upd = en && (act.hit || act.fill || act.evict);

  // a fill ages every valid entry, otherwise only those younger than the target
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      age[i] = valid_vec[i] && !sel[i] && (act.fill || (ranks[i] < limit));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_vec  <= '0;
      fill_count <= '0;
    end else if (upd) begin
      valid_vec <= valid_vec | sel;
      if (act.fill) begin
        fill_count <= fill_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (sel[i]) begin
          ranks[i] <= '0;
        end else if (age[i]) begin
          ranks[i] <= ranks[i] + RANK_W'(1);
        end
        if (sel[i] && (act.fill || act.evict)) begin
          keys[i] <= key;
        end
        if (sel[i] && act.put) begin
          values[i] <= write_value;
        end
      end
    end
  end

endmodule

// ===== rtl/core/lrc_checker.sv =====
// lrc_props: port-level assertions for lru_key_value_cache, bound to the top.
// Depends on lrc_pkg for field widths.
`timescale 1ns / 1ps

module lrc_props (
  input logic                               clk,
  input logic                               rst,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [lrc_pkg::CAP_W-1:0]          capacity,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               command,
  input logic signed [lrc_pkg::DATA_W-1:0]  key,
  input logic signed [lrc_pkg::DATA_W-1:0]  write_value,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               hit,
  input logic signed [lrc_pkg::DATA_W-1:0]  read_value,
  input logic                               evicted,
  input logic signed [lrc_pkg::DATA_W-1:0]  evicted_key
);
  import lrc_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(evicted_key))
    else $error("result beat changed under stall");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a miss never reports a stored value
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> read_value == READ_MISS)
    else $error("miss returned a value");

  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> !hit)
    else $error("eviction reported on a hit");

  a_evict_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted |-> evicted_key == '0)
    else $error("evicted key set without eviction");

endmodule

bind lru_key_value_cache lrc_props u_lrc_props (.*);

// ===== tb/sv/lrc_checker.sv =====
// lrc_checker: watches the config, input and result channels of lru_key_value_cache,
// keeps its own copy of the cache contents and LRU order, and compares every result beat.
// Depends on lrc_pkg.
`timescale 1ns / 1ps

module lrc_checker #(
  parameter int DEPTH = lrc_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [lrc_pkg::CAP_W-1:0]          capacity,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               command,
  input  logic signed [lrc_pkg::DATA_W-1:0]  key,
  input  logic signed [lrc_pkg::DATA_W-1:0]  write_value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic                               hit,
  input  logic signed [lrc_pkg::DATA_W-1:0]  read_value,
  input  logic                               evicted,
  input  logic signed [lrc_pkg::DATA_W-1:0]  evicted_key,
  output int                                 errors,
  output int                                 pending,
  output int                                 results_seen,
  output int                                 hits_seen,
  output int                                 evicts_seen
);
  import lrc_pkg::*;

  localparam int AGE_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [DATA_W-1:0] evicted_key;
  } cache_result_t;

  logic [DATA_W-1:0] slot_key   [DEPTH];
  logic [DATA_W-1:0] slot_value [DEPTH];
  logic              slot_held  [DEPTH];
  logic [AGE_W-1:0]  slot_age   [DEPTH];   // 0 = most recent
  int unsigned       filled;
  int unsigned       cap_limit;
  cache_result_t     expected_q [$];

  // slot s becomes the newest; held slots younger than limit age by one
  function automatic void make_newest(input int s, input int unsigned limit);
    int i;
    for (i = 0; i < DEPTH; i++)
      if (i != s && slot_held[i] && slot_age[i] < limit) slot_age[i] = slot_age[i] + 1'b1;
    slot_age[s] = '0;
  endfunction

  function automatic cache_result_t lookup_and_update(input logic cmd,
                                                      input logic [DATA_W-1:0] k,
                                                      input logic [DATA_W-1:0] wv);
    cache_result_t r;
    int i, s, v;
    int unsigned oldest;
    r.hit         = 1'b0;
    r.read_value  = READ_MISS;
    r.evicted     = 1'b0;
    r.evicted_key = '0;
    s = -1;
    for (i = 0; i < DEPTH; i++)
      if (s < 0 && slot_held[i] && slot_key[i] == k) s = i;
    if (s >= 0) begin
      r.hit = 1'b1;
      if (cmd == CMD_GET) r.read_value = slot_value[s];
      else slot_value[s] = wv;
      make_newest(s, slot_age[s]);
    end else if (cmd == CMD_PUT) begin
      v = -1;
      if (filled < cap_limit)
        for (i = 0; i < DEPTH; i++)
          if (v < 0 && !slot_held[i]) v = i;
      if (v >= 0) begin
        filled++;
        slot_held[v] = 1'b1;
        slot_age[v]  = '0;
        make_newest(v, 32'hFFFF_FFFF);
      end else begin
        // capacity is never below one, so at least one slot is held here
        oldest = 0;
        for (i = 0; i < DEPTH; i++)
          if (slot_held[i] && (v < 0 || slot_age[i] > oldest)) begin
            v      = i;
            oldest = slot_age[i];
          end
        r.evicted     = 1'b1;
        r.evicted_key = slot_key[v];
        make_newest(v, oldest);
      end
      slot_key[v]   = k;
      slot_value[v] = wv;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    cache_result_t got, want;
    int i;
    if (rst) begin
      for (i = 0; i < DEPTH; i++) slot_held[i] = 1'b0;
      filled       = 0;
      cap_limit    = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;
      errors       = 0;
      results_seen = 0;
      hits_seen    = 0;
      evicts_seen  = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (capacity > DEPTH) cap_limit = DEPTH;
        else if (capacity == 0) cap_limit = 1;
        else cap_limit = capacity;
      end
      if (in_valid && !in_stall)
        expected_q.push_back(lookup_and_update(command, key, write_value));
      if (out_valid && !out_stall) begin
        got = '{hit, read_value, evicted, evicted_key};
        results_seen++;
        if (hit === 1'b1) hits_seen++;
        if (evicted === 1'b1) evicts_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result beat %0d with nothing expected: %s hit=%b read=%h evicted=%b key=%h",
                     $realtime, results_seen, "", hit, read_value, evicted, evicted_key);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result beat %0d mismatch", $realtime, results_seen);
              $display("  expected hit=%b read=%h evicted=%b key=%h",
                       want.hit, want.read_value, want.evicted, want.evicted_key);
              $display("  actual   hit=%b read=%h evicted=%b key=%h",
                       got.hit, got.read_value, got.evicted, got.evicted_key);
            end
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// tb: stimulus and verdict for lru_key_value_cache; directed puts/gets, capacity sweeps,
// random traffic over a small key pool with random idling on both sides.
// Depends on lrc_pkg, lru_key_value_cache and lrc_checker.
`timescale 1ns / 1ps

module tb;
  import lrc_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int POOL_SIZE   = 24;
  localparam int HOLD_CYCLES = 200;

  localparam logic [DATA_W-1:0] KEY_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] KEY_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CAP_W-1:0]         capacity;
  logic                     in_valid;
  logic                     in_stall;
  logic                     command;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] write_value;
  logic                     out_valid;
  logic                     out_stall;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;
  logic                     evicted;
  logic signed [DATA_W-1:0] evicted_key;

  int errors, pending, results_seen, hits_seen, evicts_seen;
  int beats_sent;
  int cfg_writes;
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;

  logic [DATA_W-1:0] key_pool [POOL_SIZE];
  logic [CAP_W-1:0]  phase_cap [PHASES];

  lru_key_value_cache #(
    .DEPTH(DEPTH_DEF)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .capacity   (capacity),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .key        (key),
    .write_value(write_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .read_value (read_value),
    .evicted    (evicted),
    .evicted_key(evicted_key)
  );

  lrc_checker #(
    .DEPTH(DEPTH_DEF)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .capacity    (capacity),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .key         (key),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key),
    .errors      (errors),
    .pending     (pending),
    .results_seen(results_seen),
    .hits_seen   (hits_seen),
    .evicts_seen (evicts_seen)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // call at a rising edge; returns at the edge where the beat is taken, valid left high
  task automatic send_beat(input logic cmd, input logic [DATA_W-1:0] k,
                           input logic [DATA_W-1:0] wv);
    command     <= cmd;
    key         <= k;
    write_value <= wv;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // only while idle: drain all results, then let the result register settle
  task automatic set_capacity(input logic [CAP_W-1:0] v);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
    capacity  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // result side: random stall bursts, one long hold-off, and quiet stretches
  initial begin : receiver
    int run_len, stall_len, pick;
    bit hold_taken;
    hold_taken = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!idle_on) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        run_len = $urandom_range(1, 8);
        pick    = $urandom_range(0, 99);
        if (pick < 70) stall_len = $urandom_range(1, 2);
        else if (pick < 95) stall_len = $urandom_range(3, 6);
        else stall_len = $urandom_range(10, 30);
        out_stall <= 1'b0;
        repeat (run_len) @(posedge clk);
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int p, n, i, pick, gap, guard;
    logic              cmd;
    logic [DATA_W-1:0] k;
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    capacity    <= '0;
    in_valid    <= 1'b0;
    command     <= CMD_GET;
    key         <= '0;
    write_value <= '0;
    beats_sent  = 0;
    cfg_writes  = 0;

    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;
    key_pool[2] = KEY_MIN;
    key_pool[3] = KEY_MAX;
    for (i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    phase_cap[0] = 5'd3;
    phase_cap[1] = 5'd0;    // taken as 1
    phase_cap[2] = 5'd8;
    phase_cap[3] = 5'd17;   // saturates
    phase_cap[4] = 5'd31;
    phase_cap[5] = 5'd2;
    phase_cap[6] = CAP_W'($urandom_range(1, 15));
    phase_cap[7] = 5'd16;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: reset capacity, extreme keys and values, hits, misses, update
    send_beat(CMD_PUT, KEY_MIN, KEY_MAX);
    send_beat(CMD_PUT, KEY_MAX, KEY_MIN);
    send_beat(CMD_PUT, ALL_ONES, ALL_ONES);
    send_beat(CMD_PUT, '0, '0);
    send_beat(CMD_GET, KEY_MIN, ALL_ONES);
    send_beat(CMD_GET, KEY_MAX, '0);
    send_beat(CMD_GET, ALL_ONES, '0);
    send_beat(CMD_GET, '0, ALL_ONES);
    send_beat(CMD_GET, 32'd1, '0);
    send_beat(CMD_PUT, KEY_MAX, 32'h5A5A_5A5A);
    send_beat(CMD_GET, KEY_MAX, '0);
    send_beat(CMD_GET, 32'h1234_5678, '0);

    // capacity below the fill: misses evict, extra entries stay held
    set_capacity(5'd2);
    send_beat(CMD_PUT, 32'h0000_1111, 32'hA5A5_0001);
    send_beat(CMD_GET, ALL_ONES, '0);
    send_beat(CMD_PUT, 32'h0000_2222, 32'hA5A5_0002);
    set_capacity(5'd0);
    send_beat(CMD_PUT, 32'h0000_3333, 32'hA5A5_0003);
    send_beat(CMD_GET, 32'h0000_3333, '0);
    set_capacity(5'd31);
    send_beat(CMD_PUT, 32'h0000_4444, 32'hA5A5_0004);
    send_beat(CMD_GET, 32'h0000_1111, '0);
    send_beat(CMD_PUT, 32'h0000_4444, 32'hFFFF_0000);

    for (p = 0; p < PHASES; p++) begin
      set_capacity(phase_cap[p]);
      idle_on = (p != 2);
      if (p == 4) hold_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        cmd = ($urandom_range(0, 99) < 45) ? CMD_PUT : CMD_GET;
        if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else k = $urandom;
        send_beat(cmd, k, $urandom);
        // pressure phase keeps offering beats back to back
        if (idle_on && p != 4) begin
          pick = $urandom_range(0, 99);
          if (pick < 60) gap = 0;
          else if (pick < 90) gap = $urandom_range(1, 3);
          else if (pick < 98) gap = $urandom_range(4, 10);
          else gap = $urandom_range(20, 40);
          pause_sender(gap);
        end
      end
    end
    in_valid <= 1'b0;

    guard = 0;
    do begin
      @(negedge clk);
      guard++;
    end while (pending != 0 && guard < 20000);
    repeat (5) @(negedge clk);

    $display("Sent %0d beats across %0d capacity writes (0, 1, 2, 3, 8, 16, 17, 31 and more).",
             beats_sent, cfg_writes);
    $display("Checked %0d result beats: %0d hits, %0d evictions, %0d still expected.",
             results_seen, hits_seen, evicts_seen, pending);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Timeout: %0d beats sent, %0d results still expected", beats_sent, pending);
    $display("Test completed with failures");
    $finish;
  end

endmodule
